[rtl/core/imufp_pkg.sv]
// Shared types and constants for the IMU frame parser.
// Used by imufp_scale, imu_frame_parser_top and imufp_chk.
`default_nettype none

package imufp_pkg;

  localparam int unsigned FrameLen   = 11;
  localparam int unsigned StoreLen   = 10;
  localparam int unsigned PosW       = 4;
  localparam int unsigned RawW       = 16;
  localparam int unsigned ValueW     = 19;
  localparam int unsigned MulW       = 12;
  localparam int unsigned ShiftW     = 4;
  localparam int unsigned ProdW      = 29;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned InUserW    = 1;
  localparam int unsigned OutDataW   = 80;
  localparam int unsigned OutUserW   = 2;

  localparam logic [7:0] HeaderByte = 8'h55;
  localparam logic [7:0] TypeAccel  = 8'h51;
  localparam logic [7:0] TypeRate   = 8'h52;
  localparam logic [7:0] TypeAngle  = 8'h53;

  localparam logic [PosW-1:0] LastPos = 4'd10;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_e;

  // Decoded frame waiting for scaling
  typedef struct packed {
    kind_e                  kind;
    logic signed [RawW-1:0] raw_x;
    logic signed [RawW-1:0] raw_y;
    logic signed [RawW-1:0] raw_z;
    logic signed [RawW-1:0] extra;
  } frame_t;

  // Scale factor numerator per kind
  function automatic logic [MulW-1:0] kind_mul(kind_e kind);
    logic [MulW-1:0] m;
    case (kind)
      KIND_ACCEL: m = 12'd125;
      KIND_RATE:  m = 12'd3125;
      KIND_ANGLE: m = 12'd1125;
      default:    m = '0;
    endcase
    return m;
  endfunction

  // Scale factor denominator per kind, as a shift count
  function automatic logic [ShiftW-1:0] kind_shift(kind_e kind);
    logic [ShiftW-1:0] s;
    case (kind)
      KIND_ACCEL: s = 4'd8;
      KIND_RATE:  s = 4'd9;
      KIND_ANGLE: s = 4'd11;
      default:    s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/core/imufp_cell.sv]
// One byte cell of the frame shift chain.
// Depends on nothing; chained by imu_frame_parser_top.
`default_nettype none

module imufp_cell (
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] data_i,
  output logic      [7:0] data_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = shift_i ? data_i : byte_q;
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign data_o = byte_q;

endmodule

`default_nettype wire

[rtl/core/imufp_scale.sv]
// Scales one raw axis word to fixed point, truncating toward zero.
// Depends on imufp_pkg.
`default_nettype none

module imufp_scale (
  input  wire imufp_pkg::kind_e                   kind_i,
  input  wire logic signed [imufp_pkg::RawW-1:0]  raw_i,
  output logic signed [imufp_pkg::ValueW-1:0]     value_o
);

  logic [imufp_pkg::MulW-1:0]          mul;
  logic [imufp_pkg::ShiftW-1:0]        sh;
  logic signed [imufp_pkg::ProdW-1:0]  prod;
  logic [imufp_pkg::ProdW-1:0]         bias;
  logic signed [imufp_pkg::ProdW-1:0]  biased;
  logic signed [imufp_pkg::ProdW-1:0]  shifted;

  always_comb begin
    mul  = imufp_pkg::kind_mul(kind_i);
    sh   = imufp_pkg::kind_shift(kind_i);
    prod = $signed({{(imufp_pkg::ProdW-imufp_pkg::RawW){raw_i[imufp_pkg::RawW-1]}}, raw_i})
         * $signed({{(imufp_pkg::ProdW-imufp_pkg::MulW){1'b0}}, mul});
    // round negative products up so the shift truncates toward zero
    bias    = prod[imufp_pkg::ProdW-1] ? ((29'd1 << sh) - 29'd1) : '0;
    biased  = prod + $signed(bias);
    shifted = biased >>> sh;
    value_o = shifted[imufp_pkg::ValueW-1:0];
  end

endmodule

`default_nettype wire

[rtl/core/imu_frame_parser_top.sv]
// Top level of the IMU 11-byte serial frame parser.
// Depends on imufp_pkg, imufp_cell and imufp_scale.
`default_nettype none

// Takes one serial byte per word on the slave side; tuser flags the first byte of a
// burst, which restarts frame alignment. Bytes shift through a chain of ten byte cells
// while a running 8-bit sum follows them; the eleventh byte is compared with the sum
// and, together with header and type checks, decides whether the frame yields a result.
// A byte is taken every cycle unless the slave side stalls. A good frame's result is
// registered first in the decode register after its checksum byte, then passes through
// the constant multiply into the output register. The slave side stalls only while both
// registers hold a frame and the master side is not ready.
module imu_frame_parser_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [imufp_pkg::InDataW-1:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic [imufp_pkg::InUserW-1:0]  s_axis_tuser_i,   // [0] burst_start
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [imufp_pkg::OutDataW-1:0]      m_axis_tdata_o,   // [18:0] value_x,
                                                                // [37:19] value_y,
                                                                // [56:38] value_z,
                                                                // [72:57] extra_word
  output logic [imufp_pkg::OutUserW-1:0]      m_axis_tuser_o    // [1:0] frame_kind
);

  logic                         in_acc;
  logic [7:0]                   rx_byte;
  logic                         burst;
  logic [imufp_pkg::PosW-1:0]   pos_q, pos_d, pos_eff;
  logic [7:0]                   sum_q, sum_d, sum_eff;
  logic                         at_check;
  logic                         shift;
  logic [7:0]                   chain [imufp_pkg::StoreLen];

  logic                         type_ok;
  imufp_pkg::kind_e             kind;
  logic                         frame_ok;

  logic                         s1_valid_q, s1_valid_d;
  imufp_pkg::frame_t            s1_q, s1_d;
  logic                         s1_move;

  logic                                    out_valid_q, out_valid_d;
  logic signed [imufp_pkg::ValueW-1:0]     vx, vy, vz;
  logic [imufp_pkg::OutDataW-1:0]          odata_q, odata_d;
  logic [imufp_pkg::OutUserW-1:0]          ouser_q, ouser_d;

  assign rx_byte = s_axis_tdata_i;
  assign burst   = s_axis_tuser_i[0];

  assign s1_move         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || s1_move;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Position and sum restart on a burst start
  always_comb begin
    pos_eff  = burst ? '0 : pos_q;
    sum_eff  = burst ? '0 : sum_q;
    at_check = (pos_eff == imufp_pkg::LastPos);
    shift    = in_acc && !at_check;
    pos_d    = pos_q;
    sum_d    = sum_q;
    if (in_acc) begin
      if (at_check) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = pos_eff + 4'd1;
        sum_d = sum_eff + rx_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  // Byte chain: newest byte in cell 0, frame byte k ends up in cell 9-k
  for (genvar i = 0; i < imufp_pkg::StoreLen; i++) begin : g_cell
    if (i == 0) begin : g_head
      imufp_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .data_i (rx_byte),
        .data_o (chain[i])
      );
    end else begin : g_body
      imufp_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .data_i (chain[i-1]),
        .data_o (chain[i])
      );
    end
  end

  always_comb begin
    type_ok = 1'b1;
    kind    = imufp_pkg::KIND_ACCEL;
    case (chain[8])
      imufp_pkg::TypeAccel: kind = imufp_pkg::KIND_ACCEL;
      imufp_pkg::TypeRate:  kind = imufp_pkg::KIND_RATE;
      imufp_pkg::TypeAngle: kind = imufp_pkg::KIND_ANGLE;
      default:              type_ok = 1'b0;
    endcase
    frame_ok = in_acc && at_check && type_ok &&
               (chain[9] == imufp_pkg::HeaderByte) && (sum_eff == rx_byte);
  end

  always_comb begin
    s1_d.kind  = kind;
    s1_d.raw_x = {chain[6], chain[7]};
    s1_d.raw_y = {chain[4], chain[5]};
    s1_d.raw_z = {chain[2], chain[3]};
    s1_d.extra = (kind == imufp_pkg::KIND_RATE) ? '0 : {chain[0], chain[1]};
    if (frame_ok) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_ok) begin
      s1_q <= s1_d;
    end
  end

  imufp_scale u_scale_x (.kind_i(s1_q.kind), .raw_i(s1_q.raw_x), .value_o(vx));
  imufp_scale u_scale_y (.kind_i(s1_q.kind), .raw_i(s1_q.raw_y), .value_o(vy));
  imufp_scale u_scale_z (.kind_i(s1_q.kind), .raw_i(s1_q.raw_z), .value_o(vz));

  always_comb begin
    odata_d     = {7'd0, s1_q.extra, vz, vy, vx};
    ouser_d     = s1_q.kind;
    out_valid_d = s1_move ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      odata_q <= odata_d;
      ouser_q <= ouser_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;

endmodule

`default_nettype wire

[rtl/core/imufp_chk.sv]
// Port-level assertions for the IMU frame parser, bound to its top level.
// Depends on imufp_pkg and imu_frame_parser_top.
`default_nettype none

module imufp_chk (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_tready_i,
  input wire logic                                m_tvalid_i,
  input wire logic                                m_tready_i,
  input wire logic [imufp_pkg::OutDataW-1:0]      m_tdata_i,
  input wire logic [imufp_pkg::OutUserW-1:0]      m_tuser_i
);

  // hold a stalled result
  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result dropped while stalled");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("stalled result changed");

  a_kind_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tuser_i == imufp_pkg::KIND_ACCEL) ||
                   (m_tuser_i == imufp_pkg::KIND_RATE) ||
                   (m_tuser_i == imufp_pkg::KIND_ANGLE))
    else $error("illegal frame kind");

  a_rate_extra : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == imufp_pkg::KIND_RATE) |-> (m_tdata_i[72:57] == 16'd0))
    else $error("rate frame carries nonzero extra word");

  a_ready_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_i |-> s_tready_i)
    else $error("input stalled with empty output");

endmodule

bind imu_frame_parser_top imufp_chk u_imufp_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_tready_i(s_axis_tready_o),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tdata_i (m_axis_tdata_o),
  .m_tuser_i (m_axis_tuser_o)
);

`default_nettype wire
